### rtl/ecm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecm_pkg
// Shared word types and constants for the exon-to-transcript CDS mapper.
// ----------------------------------------------------------------------------
package ecm_pkg;

    // Reciprocal of three for a 32-bit dividend: q = (x * RECIP3) >> QSHIFT
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int          QSHIFT = 33;

    // One exon block of a record
    typedef struct packed {
        logic [30:0] record_start;
        logic [30:0] coding_start;
        logic [30:0] coding_end;
        logic        minus_strand;
        logic [30:0] block_offset;
        logic [30:0] block_length;
        logic        last_block;
    } t_in_word;

    // One mapped record
    typedef struct packed {
        logic signed [31:0] cds_first;
        logic signed [31:0] cds_last;
        logic        [31:0] transcript_length;
        logic               start_hit;
        logic               end_hit;
    } t_out_word;

    // Record totals after the last block
    typedef struct packed {
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [31:0] length;
        logic        minus_strand;
        logic        start_hit;
        logic        end_hit;
    } t_acc_word;

    // Strand-corrected positions and signed span
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] span;
        logic [31:0] mag;
        logic [31:0] length;
        logic        start_hit;
        logic        end_hit;
    } t_span_word;

endpackage

### rtl/ecm_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecm_accum
// Input register and per-record state: running length and boundary hits.
// Emits the record totals when the last block leaves the input register.
// ----------------------------------------------------------------------------
module ecm_accum
    import ecm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_acc_valid,
    input  logic      i_acc_ready,
    output t_acc_word o_acc_data
);

    t_in_word    r_in;
    logic        r_in_valid;
    logic [31:0] r_run_len;
    logic [31:0] r_start_off;
    logic [31:0] r_end_off;
    logic        r_start_seen;
    logic        r_end_seen;

    logic        w_adv;
    logic [31:0] w_bstart;
    logic [32:0] w_bend;
    logic [31:0] w_cs;
    logic [31:0] w_ce;
    logic        w_cs_in;
    logic        w_ce_in;
    logic [31:0] n_run_len;
    logic [31:0] n_start_off;
    logic [31:0] n_end_off;
    logic        n_start_seen;
    logic        n_end_seen;

    // Move the held word on unless a last block waits for the next stage
    assign w_adv       = r_in_valid && (!r_in.last_block || i_acc_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_acc_valid = r_in_valid && r_in.last_block;

    // Locate the block span and test both boundaries, ends included
    always_comb begin
        w_bstart = {1'b0, r_in.record_start} + {1'b0, r_in.block_offset};
        w_bend   = {1'b0, w_bstart} + {2'b00, r_in.block_length};
        w_cs     = {1'b0, r_in.coding_start};
        w_ce     = {1'b0, r_in.coding_end};
        w_cs_in  = (w_bstart <= w_cs) && ({1'b0, w_cs} <= w_bend);
        w_ce_in  = (w_bstart <= w_ce) && ({1'b0, w_ce} <= w_bend);
        n_run_len    = r_run_len + {1'b0, r_in.block_length};
        n_start_off  = w_cs_in ? (w_cs - w_bstart + r_run_len) : r_start_off;
        n_end_off    = w_ce_in ? (w_ce - w_bstart + r_run_len) : r_end_off;
        n_start_seen = r_start_seen || w_cs_in;
        n_end_seen   = r_end_seen || w_ce_in;
    end

    // Record totals as seen with the current block folded in
    always_comb begin
        o_acc_data.start_off    = n_start_off;
        o_acc_data.end_off      = n_end_off;
        o_acc_data.length       = n_run_len;
        o_acc_data.minus_strand = r_in.minus_strand;
        o_acc_data.start_hit    = n_start_seen;
        o_acc_data.end_hit      = n_end_seen;
    end

    // Hold the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Advance the record state; clear it after the last block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len    <= '0;
            r_start_off  <= '0;
            r_end_off    <= '0;
            r_start_seen <= 1'b0;
            r_end_seen   <= 1'b0;
        end else if (w_adv) begin
            if (r_in.last_block) begin
                r_run_len    <= '0;
                r_start_off  <= '0;
                r_end_off    <= '0;
                r_start_seen <= 1'b0;
                r_end_seen   <= 1'b0;
            end else begin
                r_run_len    <= n_run_len;
                r_start_off  <= n_start_off;
                r_end_off    <= n_end_off;
                r_start_seen <= n_start_seen;
                r_end_seen   <= n_end_seen;
            end
        end
    end

endmodule

### rtl/ecm_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecm_mirror
// Strand correction: mirror and swap on the minus strand, then form the
// signed coding span and its magnitude.
// ----------------------------------------------------------------------------
module ecm_mirror
    import ecm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc_valid,
    output logic       o_acc_ready,
    input  t_acc_word  i_acc_data,
    output logic       o_span_valid,
    input  logic       i_span_ready,
    output t_span_word o_span_data
);

    t_acc_word   r_acc;
    logic        r_acc_valid;
    logic [31:0] w_first;
    logic [31:0] w_lastpos;
    logic [31:0] w_span;

    assign o_acc_ready  = !r_acc_valid || i_span_ready;
    assign o_span_valid = r_acc_valid;

    // Mirror against the total length and swap for the minus strand
    always_comb begin
        if (r_acc.minus_strand) begin
            w_first   = r_acc.length - r_acc.end_off;
            w_lastpos = r_acc.length - r_acc.start_off;
        end else begin
            w_first   = r_acc.start_off;
            w_lastpos = r_acc.end_off;
        end
        w_span = w_lastpos - w_first;
        o_span_data.first     = w_first;
        o_span_data.span      = w_span;
        o_span_data.mag       = w_span[31] ? (32'd0 - w_span) : w_span;
        o_span_data.length    = r_acc.length;
        o_span_data.start_hit = r_acc.start_hit;
        o_span_data.end_hit   = r_acc.end_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else if (o_acc_ready) begin
            r_acc_valid <= i_acc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_acc_ready && i_acc_valid) begin
            r_acc <= i_acc_data;
        end
    end

endmodule

### rtl/ecm_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecm_trim
// Trims the coding span toward zero to a multiple of three. The remainder
// comes from a reciprocal multiply, registered, then a small correction.
// Ends in the output register.
// ----------------------------------------------------------------------------
module ecm_trim
    import ecm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_span_valid,
    output logic       o_span_ready,
    input  t_span_word i_span_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data
);

    localparam int QW = 64 - QSHIFT;

    t_span_word  r_sp;
    logic        r_sp_valid;
    logic [31:0] r_q_first;
    logic [31:0] r_q_span;
    logic [1:0]  r_q_mag_lo;
    logic [QW-1:0] r_q_quot;
    logic [31:0] r_q_length;
    logic        r_q_start_hit;
    logic        r_q_end_hit;
    logic        r_q_valid;
    t_out_word   r_out;
    logic        r_out_valid;

    logic        w_out_ready;
    logic        w_q_ready;
    logic [63:0] w_prod;
    logic [1:0]  w_q3_lo;
    logic [1:0]  w_rem;
    logic [31:0] w_trim;

    // Ready chain lets bubbles collapse while the output waits
    assign w_out_ready  = !r_out_valid || i_out_ready;
    assign w_q_ready    = !r_q_valid || w_out_ready;
    assign o_span_ready = !r_sp_valid || w_q_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // Quotient by three of the span magnitude
    assign w_prod = {32'd0, r_sp.mag} * {32'd0, RECIP3};

    // Remainder from the low bits only, then trim toward zero
    always_comb begin
        w_q3_lo = r_q_quot[1:0] + {r_q_quot[0], 1'b0};
        w_rem   = r_q_mag_lo - w_q3_lo;
        if (r_q_span[31]) begin
            w_trim = r_q_span + {30'd0, w_rem};
        end else begin
            w_trim = r_q_span - {30'd0, w_rem};
        end
    end

    // Span stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_valid <= 1'b0;
        end else if (o_span_ready) begin
            r_sp_valid <= i_span_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_span_ready && i_span_valid) begin
            r_sp <= i_span_data;
        end
    end

    // Quotient stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_q_ready) begin
            r_q_valid <= r_sp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_ready && r_sp_valid) begin
            r_q_first     <= r_sp.first;
            r_q_span      <= r_sp.span;
            r_q_mag_lo    <= r_sp.mag[1:0];
            r_q_quot      <= w_prod[63:QSHIFT];
            r_q_length    <= r_sp.length;
            r_q_start_hit <= r_sp.start_hit;
            r_q_end_hit   <= r_sp.end_hit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_q_valid) begin
            r_out.cds_first         <= r_q_first;
            r_out.cds_last          <= r_q_first + w_trim;
            r_out.transcript_length <= r_q_length;
            r_out.start_hit         <= r_q_start_hit;
            r_out.end_hit           <= r_q_end_hit;
        end
    end

endmodule

### rtl/exon_cds_coordinate_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exon_cds_coordinate_mapper
// Maps a transcript's coding region from genome to transcript coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one exon block
//   per word; all blocks of a record repeat the record and coding fields, and
//   the final block carries last_block. Output channel (o_out_valid /
//   i_out_ready / o_out_data) gives one word per record, none for other
//   blocks.
//   Throughput: one block per cycle while no last block waits in the input
//   register for a full next stage. The running length and the hit offsets
//   are computed combinationally from the input register and record state.
//   Path: a last block passes the input register, strand stage, span stage,
//   reciprocal-multiply stage and output register, in that order.
//   Reset: synchronous, active low; clears all record state and empties the
//   pipeline. No clearing pass is needed.
//   Stall: while i_out_ready is low the result holds in the output register;
//   blocks keep flowing in until a last block waits on full stages behind it.
// ----------------------------------------------------------------------------
module exon_cds_coordinate_mapper
    import ecm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic       w_acc_valid;
    logic       w_acc_ready;
    t_acc_word  w_acc_data;
    logic       w_span_valid;
    logic       w_span_ready;
    t_span_word w_span_data;

    // Fold blocks into record totals
    ecm_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_acc_valid (w_acc_valid),
        .i_acc_ready (w_acc_ready),
        .o_acc_data  (w_acc_data)
    );

    // Correct for strand and form the span
    ecm_mirror u_mirror (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc_valid  (w_acc_valid),
        .o_acc_ready  (w_acc_ready),
        .i_acc_data   (w_acc_data),
        .o_span_valid (w_span_valid),
        .i_span_ready (w_span_ready),
        .o_span_data  (w_span_data)
    );

    // Trim to whole codons and drive the result
    ecm_trim u_trim (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_span_valid (w_span_valid),
        .o_span_ready (w_span_ready),
        .i_span_data  (w_span_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
